>>> rtl/scbp_pkg.sv
// ---------------------------------------------------------------------------
// scbp_pkg
// Shared constants, register codes and a helper for the swept capsule
// broad-phase filter.
// ---------------------------------------------------------------------------
`default_nettype none

package scbp_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int ID_WIDTH        = 32;
    localparam int Q88_WIDTH       = 16;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int PROD_WIDTH      = 2 * Q88_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 1;
    localparam int GUARD_BITS      = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_START_Z  = 3'd2,
        REG_END_X    = 3'd3,
        REG_END_Y    = 3'd4,
        REG_END_Z    = 3'd5,
        REG_RADIUS   = 3'd6,
        REG_OWNER_ID = 3'd7
    } t_cfg_reg;

    // Zero scale, radius or height is treated as one LSB.
    function automatic logic [Q88_WIDTH-1:0] at_least_one(input logic [Q88_WIDTH-1:0] v);
        at_least_one = (v == '0) ? {{(Q88_WIDTH-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/scbp_sweep_box.sv
// ---------------------------------------------------------------------------
// scbp_sweep_box
// Configuration registers and the registered, radius-inflated bounding box
// of the projectile sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module scbp_sweep_box #(
    parameter int COORD_WIDTH = scbp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [scbp_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [scbp_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output logic      [scbp_pkg::ID_WIDTH-1:0]        o_owner_id,
    output logic signed [COORD_WIDTH+scbp_pkg::GUARD_BITS-1:0] o_smin [3],
    output logic signed [COORD_WIDTH+scbp_pkg::GUARD_BITS-1:0] o_smax [3]
);
    import scbp_pkg::*;

    localparam int WW = COORD_WIDTH + GUARD_BITS;

    logic signed [COORD_WIDTH-1:0] r_start [3];
    logic signed [COORD_WIDTH-1:0] r_end   [3];
    logic signed [COORD_WIDTH-1:0] n_start [3];
    logic signed [COORD_WIDTH-1:0] n_end   [3];
    logic        [Q88_WIDTH-1:0]   r_radius, n_radius;
    logic        [ID_WIDTH-1:0]    r_owner, n_owner;
    logic signed [WW-1:0]          r_smin [3];
    logic signed [WW-1:0]          r_smax [3];
    logic signed [WW-1:0]          n_smin [3];
    logic signed [WW-1:0]          n_smax [3];

    always_comb begin
        n_start  = r_start;
        n_end    = r_end;
        n_radius = r_radius;
        n_owner  = r_owner;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_START_X:  n_start[0] = i_cfg_data[COORD_WIDTH-1:0];
                REG_START_Y:  n_start[1] = i_cfg_data[COORD_WIDTH-1:0];
                REG_START_Z:  n_start[2] = i_cfg_data[COORD_WIDTH-1:0];
                REG_END_X:    n_end[0]   = i_cfg_data[COORD_WIDTH-1:0];
                REG_END_Y:    n_end[1]   = i_cfg_data[COORD_WIDTH-1:0];
                REG_END_Z:    n_end[2]   = i_cfg_data[COORD_WIDTH-1:0];
                REG_RADIUS:   n_radius   = i_cfg_data[Q88_WIDTH-1:0];
                REG_OWNER_ID: n_owner    = i_cfg_data[ID_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [WW-1:0] a, b, rad;
        rad = {{(WW-Q88_WIDTH){1'b0}}, r_radius};
        for (int i = 0; i < 3; i++) begin
            a = {{GUARD_BITS{r_start[i][COORD_WIDTH-1]}}, r_start[i]};
            b = {{GUARD_BITS{r_end[i][COORD_WIDTH-1]}}, r_end[i]};
            n_smin[i] = ((a < b) ? a : b) - rad;
            n_smax[i] = ((a > b) ? a : b) + rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
                r_smin[i]  <= '0;
                r_smax[i]  <= '0;
            end
            r_radius <= '0;
            r_owner  <= '0;
        end else begin
            r_start  <= n_start;
            r_end    <= n_end;
            r_radius <= n_radius;
            r_owner  <= n_owner;
            r_smin   <= n_smin;
            r_smax   <= n_smax;
        end
    end

    assign o_owner_id = r_owner;
    assign o_smin     = r_smin;
    assign o_smax     = r_smax;

endmodule

`default_nettype wire

>>> rtl/scbp_capsule.sv
// ---------------------------------------------------------------------------
// scbp_capsule
// Input register, skip decision and capsule scaling (radius and half
// height), registered into the second stage.
// ---------------------------------------------------------------------------
`default_nettype none

module scbp_capsule #(
    parameter int COORD_WIDTH = scbp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_ld1,
    input  wire logic                               i_ld2,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]      i_player_id,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]      i_spawn_generation,
    input  wire logic                               i_is_dead,
    input  wire logic [scbp_pkg::Q88_WIDTH-1:0]     i_size_scale,
    input  wire logic [scbp_pkg::Q88_WIDTH-1:0]     i_capsule_radius_raw,
    input  wire logic [scbp_pkg::Q88_WIDTH-1:0]     i_capsule_height_raw,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_z,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]      i_owner_id,
    output logic                                    o_skip,
    output logic [scbp_pkg::ID_WIDTH-1:0]           o_pid,
    output logic [scbp_pkg::ID_WIDTH-1:0]           o_gen,
    output logic signed [COORD_WIDTH-1:0]           o_pos_x,
    output logic signed [COORD_WIDTH-1:0]           o_pos_y,
    output logic signed [COORD_WIDTH-1:0]           o_pos_z,
    output logic [COORD_WIDTH-2:0]                  o_r,
    output logic [COORD_WIDTH-2:0]                  o_half
);
    import scbp_pkg::*;

    localparam int QRW  = SUM_WIDTH - 8;
    localparam int CMPW = (COORD_WIDTH - 1 > QRW) ? COORD_WIDTH - 1 : QRW;
    localparam logic [COORD_WIDTH-2:0] RMAX = '1;

    logic [ID_WIDTH-1:0]          r1_pid, r1_gen, r2_pid, r2_gen;
    logic                         r1_dead;
    logic [Q88_WIDTH-1:0]         r1_scale, r1_rr, r1_hh;
    logic signed [COORD_WIDTH-1:0] r1_px, r1_py, r1_pz, r2_px, r2_py, r2_pz;
    logic [COORD_WIDTH-2:0]       r2_r, r2_half, n_r, n_half;

    logic [Q88_WIDTH-1:0]  s, rr, hh;
    logic [PROD_WIDTH-1:0] prod_r, prod_h;
    logic [SUM_WIDTH-1:0]  sum_r, sum_h;
    logic [CMPW-1:0]       qr_ext, qh_ext, rmax_ext;

    always_comb begin
        s        = at_least_one(r1_scale);
        rr       = at_least_one(r1_rr);
        hh       = at_least_one(r1_hh);
        prod_r   = rr * s;
        prod_h   = hh * s;
        sum_r    = {1'b0, prod_r} + SUM_WIDTH'(128);
        sum_h    = {1'b0, prod_h} + SUM_WIDTH'(256);
        qr_ext   = CMPW'(sum_r[SUM_WIDTH-1:8]);
        qh_ext   = CMPW'(sum_h[SUM_WIDTH-1:9]);
        rmax_ext = CMPW'(RMAX);
        n_r      = (qr_ext > rmax_ext) ? RMAX : qr_ext[COORD_WIDTH-2:0];
        n_half   = (qh_ext > rmax_ext) ? RMAX : qh_ext[COORD_WIDTH-2:0];
    end

    assign o_skip = r1_dead || (r1_pid == i_owner_id);

    always_ff @(posedge i_clk) begin
        if (i_ld1) begin
            r1_pid   <= i_player_id;
            r1_gen   <= i_spawn_generation;
            r1_dead  <= i_is_dead;
            r1_scale <= i_size_scale;
            r1_rr    <= i_capsule_radius_raw;
            r1_hh    <= i_capsule_height_raw;
            r1_px    <= i_pos_x;
            r1_py    <= i_pos_y;
            r1_pz    <= i_pos_z;
        end
        if (i_ld2) begin
            r2_pid  <= r1_pid;
            r2_gen  <= r1_gen;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_pz   <= r1_pz;
            r2_r    <= n_r;
            r2_half <= n_half;
        end
    end

    assign o_pid   = r2_pid;
    assign o_gen   = r2_gen;
    assign o_pos_x = r2_px;
    assign o_pos_y = r2_py;
    assign o_pos_z = r2_pz;
    assign o_r     = r2_r;
    assign o_half  = r2_half;

endmodule

`default_nettype wire

>>> rtl/scbp_overlap.sv
// ---------------------------------------------------------------------------
// scbp_overlap
// Capsule box, inclusive box-versus-box test and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module scbp_overlap #(
    parameter int COORD_WIDTH = scbp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_ld,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]      i_pid,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]      i_gen,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_z,
    input  wire logic [COORD_WIDTH-2:0]             i_r,
    input  wire logic [COORD_WIDTH-2:0]             i_half,
    input  wire logic signed [COORD_WIDTH+scbp_pkg::GUARD_BITS-1:0] i_smin [3],
    input  wire logic signed [COORD_WIDTH+scbp_pkg::GUARD_BITS-1:0] i_smax [3],
    output logic                                    o_hit,
    output logic [scbp_pkg::ID_WIDTH-1:0]           o_hit_player_id,
    output logic [scbp_pkg::ID_WIDTH-1:0]           o_hit_generation,
    output logic signed [COORD_WIDTH-1:0]           o_axis_x,
    output logic signed [COORD_WIDTH-1:0]           o_axis_y,
    output logic signed [COORD_WIDTH-1:0]           o_end_a_z,
    output logic signed [COORD_WIDTH-1:0]           o_end_b_z,
    output logic [COORD_WIDTH-2:0]                  o_scaled_radius
);
    import scbp_pkg::*;

    localparam int WW = COORD_WIDTH + GUARD_BITS;
    localparam logic signed [WW-1:0] CMAX =
        {{(WW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [WW-1:0] CMIN =
        {{(WW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [WW-1:0] v);
        if (v > CMAX)
            sat = CMAX[COORD_WIDTH-1:0];
        else if (v < CMIN)
            sat = CMIN[COORD_WIDTH-1:0];
        else
            sat = v[COORD_WIDTH-1:0];
    endfunction

    logic signed [WW-1:0] px, py, pz, rw, hw, d, ad, za, zb;
    logic signed [WW-1:0] cmin [3];
    logic signed [WW-1:0] cmax [3];
    logic [2:0]           ov;

    logic [ID_WIDTH-1:0]           r_pid, r_gen;
    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_za, r_zb;
    logic [COORD_WIDTH-2:0]        r_r;

    always_comb begin
        px = {{GUARD_BITS{i_pos_x[COORD_WIDTH-1]}}, i_pos_x};
        py = {{GUARD_BITS{i_pos_y[COORD_WIDTH-1]}}, i_pos_y};
        pz = {{GUARD_BITS{i_pos_z[COORD_WIDTH-1]}}, i_pos_z};
        rw = {{(GUARD_BITS+1){1'b0}}, i_r};
        hw = {{(GUARD_BITS+1){1'b0}}, i_half};
        d  = hw - rw;
        ad = d[WW-1] ? -d : d;
        za = pz - d;
        zb = pz + d;
        cmin[0] = px - rw;
        cmax[0] = px + rw;
        cmin[1] = py - rw;
        cmax[1] = py + rw;
        cmin[2] = pz - ad - rw;
        cmax[2] = pz + ad + rw;
        for (int i = 0; i < 3; i++) begin
            ov[i] = (i_smin[i] <= cmax[i]) && (cmin[i] <= i_smax[i]);
        end
    end

    assign o_hit = &ov;

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_pid <= i_pid;
            r_gen <= i_gen;
            r_ax  <= i_pos_x;
            r_ay  <= i_pos_y;
            r_za  <= sat(za);
            r_zb  <= sat(zb);
            r_r   <= i_r;
        end
    end

    assign o_hit_player_id  = r_pid;
    assign o_hit_generation = r_gen;
    assign o_axis_x         = r_ax;
    assign o_axis_y         = r_ay;
    assign o_end_a_z        = r_za;
    assign o_end_b_z        = r_zb;
    assign o_scaled_radius  = r_r;

endmodule

`default_nettype wire

>>> rtl/swept_capsule_broad_phase_filter.sv
// ---------------------------------------------------------------------------
// swept_capsule_broad_phase_filter
// Filters player records against a radius-inflated projectile sweep box and
// emits the vertical capsule of every live, non-owner player that touches it.
//
//   channel   direction  handshake               payload
//   input     in         i_in_valid/o_in_stall   player record fields
//   output    out        o_out_valid/i_out_stall capsule result fields
//   config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// One record per cycle unless the input is stalled; three register stages
// (input, scaled capsule, result) carry a hit through in that order.
// Records that are dead, owned or miss are dropped in flight.
// Synchronous active-low reset clears valids and sweep-box registers to zero.
// Output stall backs up through the stages; input stall rises only when
// every stage holds a record and the output is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module swept_capsule_broad_phase_filter #(
    parameter int COORD_WIDTH = scbp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [scbp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [scbp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]       i_player_id,
    input  wire logic [scbp_pkg::ID_WIDTH-1:0]       i_spawn_generation,
    input  wire logic                                i_is_dead,
    input  wire logic [scbp_pkg::Q88_WIDTH-1:0]      i_size_scale,
    input  wire logic [scbp_pkg::Q88_WIDTH-1:0]      i_capsule_radius_raw,
    input  wire logic [scbp_pkg::Q88_WIDTH-1:0]      i_capsule_height_raw,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_z,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [scbp_pkg::ID_WIDTH-1:0]            o_hit_player_id,
    output logic [scbp_pkg::ID_WIDTH-1:0]            o_hit_generation,
    output logic signed [COORD_WIDTH-1:0]            o_axis_x,
    output logic signed [COORD_WIDTH-1:0]            o_axis_y,
    output logic signed [COORD_WIDTH-1:0]            o_end_a_z,
    output logic signed [COORD_WIDTH-1:0]            o_end_b_z,
    output logic [COORD_WIDTH-2:0]                   o_scaled_radius
);
    import scbp_pkg::*;

    localparam int WW = COORD_WIDTH + GUARD_BITS;

    logic [ID_WIDTH-1:0]           owner_id, s2_pid, s2_gen;
    logic signed [WW-1:0]          smin [3];
    logic signed [WW-1:0]          smax [3];
    logic signed [COORD_WIDTH-1:0] s2_px, s2_py, s2_pz;
    logic [COORD_WIDTH-2:0]        s2_r, s2_half;
    logic                          skip, hit;

    logic r_v1, r_v2, r_ov, n_v1, n_v2, n_ov;
    logic out_free, s2_go, s1_go, ld1, ld2, ld_out;

    assign out_free   = !r_ov || !i_out_stall;
    assign s2_go      = !r_v2 || out_free;
    assign s1_go      = !r_v1 || s2_go;
    assign o_in_stall = !s1_go;
    assign ld1        = i_in_valid && s1_go;
    assign ld2        = s2_go && r_v1;
    assign ld_out     = out_free && r_v2 && hit;

    always_comb begin
        n_v1 = s1_go ? i_in_valid : r_v1;
        n_v2 = s2_go ? (r_v1 && !skip) : r_v2;
        n_ov = out_free ? (r_v2 && hit) : r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_ov <= n_ov;
        end
    end

    assign o_out_valid = r_ov;

    scbp_sweep_box #(.COORD_WIDTH(COORD_WIDTH)) u_sweep_box (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_owner_id  (owner_id),
        .o_smin      (smin),
        .o_smax      (smax)
    );

    scbp_capsule #(.COORD_WIDTH(COORD_WIDTH)) u_capsule (
        .i_clk                (i_clk),
        .i_ld1                (ld1),
        .i_ld2                (ld2),
        .i_player_id          (i_player_id),
        .i_spawn_generation   (i_spawn_generation),
        .i_is_dead            (i_is_dead),
        .i_size_scale         (i_size_scale),
        .i_capsule_radius_raw (i_capsule_radius_raw),
        .i_capsule_height_raw (i_capsule_height_raw),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_pos_z              (i_pos_z),
        .i_owner_id           (owner_id),
        .o_skip               (skip),
        .o_pid                (s2_pid),
        .o_gen                (s2_gen),
        .o_pos_x              (s2_px),
        .o_pos_y              (s2_py),
        .o_pos_z              (s2_pz),
        .o_r                  (s2_r),
        .o_half               (s2_half)
    );

    scbp_overlap #(.COORD_WIDTH(COORD_WIDTH)) u_overlap (
        .i_clk            (i_clk),
        .i_ld             (ld_out),
        .i_pid            (s2_pid),
        .i_gen            (s2_gen),
        .i_pos_x          (s2_px),
        .i_pos_y          (s2_py),
        .i_pos_z          (s2_pz),
        .i_r              (s2_r),
        .i_half           (s2_half),
        .i_smin           (smin),
        .i_smax           (smax),
        .o_hit            (hit),
        .o_hit_player_id  (o_hit_player_id),
        .o_hit_generation (o_hit_generation),
        .o_axis_x         (o_axis_x),
        .o_axis_y         (o_axis_y),
        .o_end_a_z        (o_end_a_z),
        .o_end_b_z        (o_end_b_z),
        .o_scaled_radius  (o_scaled_radius)
    );

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_ov && i_out_stall))
        else $error("input stalled while a stage is free");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_ov && i_out_stall) |-> o_in_stall)
        else $error("transfer accepted into a full pipeline");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !(r_v2 && hit)) |=> !o_out_valid)
        else $error("result repeated after its transfer");

    a_s2_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !skip && !o_in_stall) |=> r_v2)
        else $error("live record lost between stages");

endmodule

`default_nettype wire
